/* hw/rtl/gtpu_pol_pkg.sv */
// ----------------------------------------------------------------------------
// gtpu_pol_pkg - shared types and constants
// item codes, verdicts, colors and the front-to-back command struct
// ----------------------------------------------------------------------------
`default_nettype none
package gtpu_pol_pkg;
	localparam int FlowSlots = 1024;
	localparam int SlotW = $clog2(FlowSlots);
	localparam int QDepth = 2;

	localparam logic [1:0] MODE_PKT  = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_LOAD = 2'd2;

	localparam logic [2:0] SEL_CBS   = 3'd0;
	localparam logic [2:0] SEL_CIR   = 3'd1;
	localparam logic [2:0] SEL_EBS   = 3'd2;
	localparam logic [2:0] SEL_EIR   = 3'd3;
	localparam logic [2:0] SEL_CTOK  = 3'd4;
	localparam logic [2:0] SEL_ETOK  = 3'd5;
	localparam logic [2:0] SEL_DSCP  = 3'd6;
	localparam logic [2:0] SEL_FLAGS = 3'd7;

	localparam logic [2:0] VERDICT_FWD     = 3'd0;
	localparam logic [2:0] VERDICT_RED     = 3'd1;
	localparam logic [2:0] VERDICT_UNKNOWN = 3'd2;
	localparam logic [2:0] VERDICT_BAD_GTP = 3'd3;
	localparam logic [2:0] VERDICT_NOT_V4  = 3'd4;

	localparam logic [1:0] COLOR_GREEN  = 2'd0;
	localparam logic [1:0] COLOR_YELLOW = 2'd1;
	localparam logic [1:0] COLOR_RED    = 2'd2;

	typedef enum logic [1:0] {
		CMD_PKT  = 2'b01,
		CMD_LOAD = 2'b10
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [SlotW-1:0] slot;
		logic hdr_bad;   // gtp checks failed
		logic not_v4;
		logic [15:0] len;
		logic [2:0] sel;
		logic [31:0] val;
		logic [31:0] now;  // seconds count at accept
	} cmd_t;

	localparam int CmdW = $bits(cmd_t);
endpackage
`default_nettype wire

/* hw/rtl/gtpu_decap_two_rate_policer.sv */
// ----------------------------------------------------------------------------
// gtpu_decap_two_rate_policer - gtp-u decap checks with two-rate policer
// front classifier, command fifo, flow-table bucket engine
// ----------------------------------------------------------------------------
// A packet beat goes through the bucket engine as fifo pop, table read, refill
// multiply, color and write back, and result; a load beat as fifo pop and table
// write, and a tick beat is absorbed by the front. The engine works on one
// command at a time because each packet reads and rewrites its flow entry;
// the two-entry fifo lets the front keep taking beats while it is busy and
// while a result waits on the master side. Flow entries live in rams and are
// undefined until loaded; after reset the engine clears the flow flags, one
// slot per cycle, before it takes its first command.
`default_nettype none
module gtpu_decap_two_rate_policer (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic cfg_data,                  // policy_mode
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// mode[1:0] flow_index[11:2] gtp_version[14:12] gtp_protocol_type[15]
	// gtp_npdu_flag[16] gtp_message_type[24:17] inner_ip_version[28:25]
	// packet_length[44:29] load_select[47:45] load_value[79:48]
	input  wire logic [79:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	// verdict[2:0] color[4:3] rewrite_tos[5] new_tos[13:6]
	// commit_tokens_left[45:14] excess_tokens_left[77:46]
	output logic [79:0] m_axis_tdata
);
	logic policy_mode_q;
	logic push, full, pop, nonempty;
	gtpu_pol_pkg::cmd_t cmd_w, cmd_r;
	logic [2:0] verdict;
	logic [1:0] color;
	logic rewrite_tos;
	logic [7:0] new_tos;
	logic [31:0] ct, et;

	// config register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			policy_mode_q <= cfg_data;
		end
	end

	gtpu_pol_front u_front (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready,
		.mode(s_axis_tdata[1:0]), .flow_index(s_axis_tdata[11:2]),
		.gtp_version(s_axis_tdata[14:12]), .gtp_protocol_type(s_axis_tdata[15]),
		.gtp_npdu_flag(s_axis_tdata[16]), .gtp_message_type(s_axis_tdata[24:17]),
		.inner_ip_version(s_axis_tdata[28:25]), .packet_length(s_axis_tdata[44:29]),
		.load_select(s_axis_tdata[47:45]), .load_value(s_axis_tdata[79:48]),
		.push, .cmd(cmd_w), .full
	);

	gtpu_pol_queue u_queue (
		.clk, .arst_n, .push, .wdata(cmd_w), .full,
		.pop, .rdata(cmd_r), .nonempty
	);

	gtpu_pol_back u_back (
		.clk, .arst_n, .policy_mode_q, .q_nonempty(nonempty), .q_cmd(cmd_r), .q_pop(pop),
		.m_axis_tvalid, .m_axis_tready, .verdict, .color, .rewrite_tos, .new_tos,
		.commit_tokens_left(ct), .excess_tokens_left(et)
	);

	assign m_axis_tdata = {2'b00, et, ct, new_tos, rewrite_tos, color, verdict};
endmodule
`default_nettype wire

/* hw/rtl/gtpu_pol_ram.sv */
// ----------------------------------------------------------------------------
// gtpu_pol_ram - generic single-port-write ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module gtpu_pol_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  wire logic clk,
	input  wire logic we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0] wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/gtpu_pol_front.sv */
// ----------------------------------------------------------------------------
// gtpu_pol_front - accept and classify items
// counts ticks, checks headers, pushes packet and load commands
// ----------------------------------------------------------------------------
`default_nettype none
module gtpu_pol_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [1:0] mode,
	input  wire logic [9:0] flow_index,
	input  wire logic [2:0] gtp_version,
	input  wire logic gtp_protocol_type,
	input  wire logic gtp_npdu_flag,
	input  wire logic [7:0] gtp_message_type,
	input  wire logic [3:0] inner_ip_version,
	input  wire logic [15:0] packet_length,
	input  wire logic [2:0] load_select,
	input  wire logic [31:0] load_value,
	output logic push,
	output gtpu_pol_pkg::cmd_t cmd,
	input  wire logic full
);
	logic [31:0] sec_q;
	logic acc;
	logic [gtpu_pol_pkg::SlotW-1:0] slot;

	assign slot = gtpu_pol_pkg::SlotW'(flow_index % gtpu_pol_pkg::FlowSlots);
	assign s_axis_tready = !full;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign push = acc && (mode == gtpu_pol_pkg::MODE_PKT || mode == gtpu_pol_pkg::MODE_LOAD);

	always_comb begin
		cmd.kind = (mode == gtpu_pol_pkg::MODE_PKT) ? gtpu_pol_pkg::CMD_PKT
			: gtpu_pol_pkg::CMD_LOAD;
		cmd.slot = slot;
		cmd.hdr_bad = gtp_version != 3'd1 || !gtp_protocol_type || gtp_npdu_flag
			|| gtp_message_type != 8'hFF;
		cmd.not_v4 = inner_ip_version != 4'd4;
		cmd.len = packet_length;
		cmd.sel = load_select;
		cmd.val = load_value;
		cmd.now = sec_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= '0;
		end else if (acc && mode == gtpu_pol_pkg::MODE_TICK) begin
			sec_q <= sec_q + 32'd1;
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/gtpu_pol_queue.sv */
// ----------------------------------------------------------------------------
// gtpu_pol_queue - short command fifo
// decouples the classifier from the bucket engine
// ----------------------------------------------------------------------------
`default_nettype none
module gtpu_pol_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire gtpu_pol_pkg::cmd_t wdata,
	output logic full,
	input  wire logic pop,
	output gtpu_pol_pkg::cmd_t rdata,
	output logic nonempty
);
	localparam int PtrW = $clog2(gtpu_pol_pkg::QDepth);
	gtpu_pol_pkg::cmd_t ent_q [gtpu_pol_pkg::QDepth];
	logic [PtrW-1:0] wp_q, rp_q;
	logic [PtrW:0] cnt_q;

	assign full = cnt_q == (PtrW+1)'(gtpu_pol_pkg::QDepth);
	assign nonempty = cnt_q != '0;
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + PtrW'(1);
			if (pop) rp_q <= rp_q + PtrW'(1);
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/gtpu_pol_back.sv */
// ----------------------------------------------------------------------------
// gtpu_pol_back - flow table and bucket engine
// read, multiply, refill, color and write back one entry per packet command
// ----------------------------------------------------------------------------
`default_nettype none
module gtpu_pol_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic policy_mode_q,
	input  wire logic q_nonempty,
	input  wire gtpu_pol_pkg::cmd_t q_cmd,
	output logic q_pop,
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [2:0] verdict,
	output logic [1:0] color,
	output logic rewrite_tos,
	output logic [7:0] new_tos,
	output logic [31:0] commit_tokens_left,
	output logic [31:0] excess_tokens_left
);
	localparam int SW = gtpu_pol_pkg::SlotW;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_MUL   = 5'b00100,
		ST_DECIDE = 5'b01000,
		ST_OUT   = 5'b10000
	} st_t;
	st_t st_q;

	gtpu_pol_pkg::cmd_t c_q;
	logic [1:0] fl_r;
	logic [31:0] ct_r, et_r, cb_r, cr_r, eb_r, er_r, ep_r;
	logic [5:0] ds_r;
	logic [63:0] cadd_q, eadd_q;
	logic [31:0] dt;

	// flag clearing pass after reset, one slot per cycle
	logic clr_busy_q;
	logic [SW-1:0] clr_q;

	// write ports
	logic we_ct, we_et, we_ep;
	logic [31:0] wd_ct, wd_et, wd_ep;
	logic we_fl;
	logic [SW-1:0] wa_fl;
	logic [1:0] wd_fl;
	logic ld;
	assign ld = st_q == ST_READ && c_q.kind == gtpu_pol_pkg::CMD_LOAD;

	gtpu_pol_ram #(.Width(32), .Depth(gtpu_pol_pkg::FlowSlots)) u_cb (.clk,
		.we(ld && c_q.sel == gtpu_pol_pkg::SEL_CBS), .waddr(c_q.slot), .wdata(c_q.val),
		.raddr(c_q.slot), .rdata(cb_r));
	gtpu_pol_ram #(.Width(32), .Depth(gtpu_pol_pkg::FlowSlots)) u_cr (.clk,
		.we(ld && c_q.sel == gtpu_pol_pkg::SEL_CIR), .waddr(c_q.slot), .wdata(c_q.val),
		.raddr(c_q.slot), .rdata(cr_r));
	gtpu_pol_ram #(.Width(32), .Depth(gtpu_pol_pkg::FlowSlots)) u_eb (.clk,
		.we(ld && c_q.sel == gtpu_pol_pkg::SEL_EBS), .waddr(c_q.slot), .wdata(c_q.val),
		.raddr(c_q.slot), .rdata(eb_r));
	gtpu_pol_ram #(.Width(32), .Depth(gtpu_pol_pkg::FlowSlots)) u_er (.clk,
		.we(ld && c_q.sel == gtpu_pol_pkg::SEL_EIR), .waddr(c_q.slot), .wdata(c_q.val),
		.raddr(c_q.slot), .rdata(er_r));
	gtpu_pol_ram #(.Width(6), .Depth(gtpu_pol_pkg::FlowSlots)) u_ds (.clk,
		.we(ld && c_q.sel == gtpu_pol_pkg::SEL_DSCP), .waddr(c_q.slot),
		.wdata(c_q.val[5:0]), .raddr(c_q.slot), .rdata(ds_r));
	gtpu_pol_ram #(.Width(32), .Depth(gtpu_pol_pkg::FlowSlots)) u_ct (.clk,
		.we(we_ct), .waddr(c_q.slot), .wdata(wd_ct), .raddr(c_q.slot), .rdata(ct_r));
	gtpu_pol_ram #(.Width(32), .Depth(gtpu_pol_pkg::FlowSlots)) u_et (.clk,
		.we(we_et), .waddr(c_q.slot), .wdata(wd_et), .raddr(c_q.slot), .rdata(et_r));
	gtpu_pol_ram #(.Width(32), .Depth(gtpu_pol_pkg::FlowSlots)) u_ep (.clk,
		.we(we_ep), .waddr(c_q.slot), .wdata(wd_ep), .raddr(c_q.slot), .rdata(ep_r));
	gtpu_pol_ram #(.Width(2), .Depth(gtpu_pol_pkg::FlowSlots)) u_fl (.clk,
		.we(we_fl), .waddr(wa_fl), .wdata(wd_fl), .raddr(c_q.slot), .rdata(fl_r));

	assign dt = c_q.now - ep_r;

	// refill and charge, from registered products
	logic [31:0] cl, el;
	logic [31:0] cnew, enew;
	logic [1:0] col;
	logic pol, known;
	always_comb begin
		cl = ct_r;
		el = et_r;
		if (dt != '0) begin
			if (cadd_q >= {32'd0, cb_r}) cl = cb_r;
			else if ({32'd0, ct_r} + cadd_q < {32'd0, cb_r}) cl = ct_r + cadd_q[31:0];
			else cl = cb_r;
			if (eadd_q >= {32'd0, eb_r}) el = eb_r;
			else if ({32'd0, et_r} + eadd_q < {32'd0, eb_r}) el = et_r + eadd_q[31:0];
			else el = eb_r;
		end
		cnew = cl;
		enew = el;
		if ({16'd0, c_q.len} <= cl) begin
			cnew = cl - {16'd0, c_q.len};
			col = gtpu_pol_pkg::COLOR_GREEN;
		end else if ({16'd0, c_q.len} <= el) begin
			enew = el - {16'd0, c_q.len};
			col = gtpu_pol_pkg::COLOR_YELLOW;
		end else begin
			col = gtpu_pol_pkg::COLOR_RED;
		end
		known = fl_r[0] && !c_q.hdr_bad && !c_q.not_v4;
		pol = known && fl_r[1];
	end

	always_comb begin
		we_ct = (ld && c_q.sel == gtpu_pol_pkg::SEL_CTOK) || (st_q == ST_DECIDE && pol);
		we_et = (ld && c_q.sel == gtpu_pol_pkg::SEL_ETOK) || (st_q == ST_DECIDE && pol);
		we_ep = (ld && (c_q.sel == gtpu_pol_pkg::SEL_CTOK || c_q.sel == gtpu_pol_pkg::SEL_ETOK))
			|| (st_q == ST_DECIDE && pol);
		wd_ct = ld ? c_q.val : cnew;
		wd_et = ld ? c_q.val : enew;
		wd_ep = c_q.now;
		we_fl = clr_busy_q || (ld && c_q.sel == gtpu_pol_pkg::SEL_FLAGS);
		wa_fl = clr_busy_q ? clr_q : c_q.slot;
		wd_fl = clr_busy_q ? 2'd0 : c_q.val[1:0];
	end

	assign q_pop = st_q == ST_IDLE && q_nonempty && !clr_busy_q;
	assign m_axis_tvalid = st_q == ST_OUT;

	always_ff @(posedge clk) begin
		if (q_pop) c_q <= q_cmd;
		if (st_q == ST_MUL) begin
			cadd_q <= {32'd0, cr_r} * {32'd0, dt};
			eadd_q <= {32'd0, er_r} * {32'd0, dt};
		end
		if (st_q == ST_DECIDE) begin
			new_tos <= known ? {ds_r, 2'b00} : 8'd0;
			commit_tokens_left <= pol ? cnew : 32'd0;
			excess_tokens_left <= pol ? enew : 32'd0;
			color <= !known ? gtpu_pol_pkg::COLOR_GREEN
				: (pol ? col : gtpu_pol_pkg::COLOR_RED);
			priority if (c_q.hdr_bad) begin
				verdict <= gtpu_pol_pkg::VERDICT_BAD_GTP;
				rewrite_tos <= 1'b0;
			end else if (c_q.not_v4) begin
				verdict <= gtpu_pol_pkg::VERDICT_NOT_V4;
				rewrite_tos <= 1'b0;
			end else if (!fl_r[0]) begin
				verdict <= gtpu_pol_pkg::VERDICT_UNKNOWN;
				rewrite_tos <= 1'b0;
			end else if (!pol || col == gtpu_pol_pkg::COLOR_RED) begin
				verdict <= policy_mode_q ? gtpu_pol_pkg::VERDICT_FWD
					: gtpu_pol_pkg::VERDICT_RED;
				rewrite_tos <= policy_mode_q;
			end else begin
				verdict <= gtpu_pol_pkg::VERDICT_FWD;
				rewrite_tos <= !policy_mode_q && col == gtpu_pol_pkg::COLOR_YELLOW;
			end
		end
	end

	// flow flags read as zero until loaded: walk every slot once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_q <= '0;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + SW'(1);
			if (clr_q == SW'(gtpu_pol_pkg::FlowSlots - 1)) clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			unique case (st_q)
				ST_IDLE:   if (q_pop) st_q <= ST_READ;
				ST_READ:   st_q <= (c_q.kind == gtpu_pol_pkg::CMD_LOAD) ? ST_IDLE : ST_MUL;
				ST_MUL:    st_q <= ST_DECIDE;
				ST_DECIDE: st_q <= ST_OUT;
				ST_OUT:    if (m_axis_tready) st_q <= ST_IDLE;
				default:   st_q <= ST_IDLE;
			endcase
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> st_q == ST_READ) else $error("pop without read");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(verdict) && $stable(commit_tokens_left))
		else $error("result changed while stalled");
	a_red_nocharge: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && verdict != gtpu_pol_pkg::VERDICT_FWD
		&& verdict != gtpu_pol_pkg::VERDICT_RED |-> !rewrite_tos)
		else $error("rewrite on header drop");
	a_clr_nopop: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !q_pop) else $error("pop during flag clearing");
endmodule
`default_nettype wire
